/* sv/ssr_pkg.sv */
// ssr_pkg: shared types, command, phase and register codes for the soft-start
// ramp sequencer. Used by every module of the block; no dependencies.
package ssr_pkg;

  localparam int unsigned VoltW  = 16;
  localparam int unsigned CurrW  = 15;
  localparam int unsigned SecW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // ramp phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DELAY = 2'd1;
  localparam logic [1:0] PH_VOLT  = 2'd2;
  localparam logic [1:0] PH_CURR  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START_DELAY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VOLT_DWELL  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CURR_DWELL  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VOLT_TARGET = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CURR_TARGET = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VOLT_INCR   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CURR_INCR   = 3'd6;

  typedef struct packed {
    logic [SecW-1:0]  start_delay;
    logic [SecW-1:0]  volt_dwell;
    logic [SecW-1:0]  curr_dwell;
    logic [VoltW-1:0] volt_target;
    logic [CurrW-1:0] curr_target;
    logic [VoltW-1:0] volt_incr;
    logic [CurrW-1:0] curr_incr;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [VoltW-1:0] volt_level;
    logic [CurrW-1:0] curr_level;
    logic [SecW-1:0]  delay_cnt;
    logic [SecW-1:0]  dwell_cnt;
    logic             needs_sample;
  } seq_state_t;

  typedef struct packed {
    logic [VoltW-1:0] voltage_setpoint;
    logic [CurrW-1:0] current_setpoint;
    logic             power_write;
    logic [SecW-1:0]  delay_remaining;
    logic [SecW-1:0]  dwell_remaining;
    logic [1:0]       ramp_phase;
    logic             aborted;
  } result_t;

endpackage

/* sv/ssr_cfg_regs.sv */
// ssr_cfg_regs: configuration register file of the ramp sequencer.
// Depends on ssr_pkg.
module ssr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [ssr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ssr_pkg::CfgDataW-1:0]   cfg_data,
  output ssr_pkg::cfg_t                  cfg
);

  ssr_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      case (cfg_index)
        ssr_pkg::REG_START_DELAY: cfg_nxt.start_delay = cfg_data;
        ssr_pkg::REG_VOLT_DWELL:  cfg_nxt.volt_dwell  = cfg_data;
        ssr_pkg::REG_CURR_DWELL:  cfg_nxt.curr_dwell  = cfg_data;
        ssr_pkg::REG_VOLT_TARGET: cfg_nxt.volt_target = cfg_data;
        ssr_pkg::REG_CURR_TARGET: cfg_nxt.curr_target = cfg_data[ssr_pkg::CurrW-1:0];
        ssr_pkg::REG_VOLT_INCR:   cfg_nxt.volt_incr   = cfg_data;
        ssr_pkg::REG_CURR_INCR:   cfg_nxt.curr_incr   = cfg_data[ssr_pkg::CurrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay <= 16'd0;
      cfg_r.volt_dwell  <= 16'd1;
      cfg_r.curr_dwell  <= 16'd1;
      cfg_r.volt_target <= 16'd0;
      cfg_r.curr_target <= 15'd0;
      cfg_r.volt_incr   <= 16'd1000;
      cfg_r.curr_incr   <= 15'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/ssr_step.sv */
// ssr_step: combinational next-state and result logic for one item.
// Depends on ssr_pkg.
module ssr_step (
  input  ssr_pkg::cfg_t                cfg,
  input  ssr_pkg::seq_state_t          cur,
  input  logic [1:0]                   command,
  input  logic [ssr_pkg::VoltW-1:0]    volt_rb,
  input  logic [ssr_pkg::CurrW-1:0]    curr_rb,
  output ssr_pkg::seq_state_t          nxt,
  output ssr_pkg::result_t             res
);

  always_comb begin
    logic                     begin_v, begin_c, step_v, step_c, ended, wrote, zero_rb;
    logic                     from_rb;
    logic [ssr_pkg::VoltW-1:0] v_base, v_clamp;
    logic [ssr_pkg::CurrW-1:0] c_base, c_clamp;
    logic [ssr_pkg::VoltW:0]   v_sum;
    logic [ssr_pkg::CurrW:0]   c_sum;

    nxt     = cur;
    begin_v = 1'b0;
    begin_c = 1'b0;
    step_v  = 1'b0;
    step_c  = 1'b0;
    ended   = 1'b0;
    wrote   = 1'b0;
    from_rb = 1'b0;
    zero_rb = (volt_rb == '0) || (curr_rb == '0);

    case (command)
      ssr_pkg::CMD_START: begin
        if (cur.phase == ssr_pkg::PH_IDLE) begin
          nxt.dwell_cnt    = '0;
          nxt.needs_sample = 1'b0;
          if (cfg.start_delay == '0) begin
            nxt.phase = ssr_pkg::PH_VOLT;
            begin_v   = 1'b1;
          end else begin
            nxt.phase     = ssr_pkg::PH_DELAY;
            nxt.delay_cnt = cfg.start_delay;
          end
        end
      end
      ssr_pkg::CMD_STOP: begin
        if (cur.phase != ssr_pkg::PH_IDLE) begin
          nxt.phase        = ssr_pkg::PH_IDLE;
          nxt.delay_cnt    = '0;
          nxt.dwell_cnt    = '0;
          nxt.needs_sample = 1'b0;
          ended            = 1'b1;
        end
      end
      ssr_pkg::CMD_TICK: begin
        case (cur.phase)
          ssr_pkg::PH_DELAY: begin
            if (cur.delay_cnt > 16'd1) begin
              nxt.delay_cnt = cur.delay_cnt - 16'd1;
            end else begin
              nxt.phase = ssr_pkg::PH_VOLT;
              begin_v   = 1'b1;
            end
          end
          ssr_pkg::PH_VOLT, ssr_pkg::PH_CURR: begin
            if (cur.phase == ssr_pkg::PH_CURR && cur.needs_sample) begin
              begin_c = 1'b1;
            end else if (cur.dwell_cnt > 16'd1) begin
              nxt.dwell_cnt = cur.dwell_cnt - 16'd1;
            end else begin
              nxt.dwell_cnt = '0;
              if (cur.phase == ssr_pkg::PH_VOLT) step_v = 1'b1;
              else step_c = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // phase entry: sample the readbacks, abort on a zero reading
    if (begin_v) begin
      nxt.delay_cnt = '0;
      if (zero_rb) begin
        ended = 1'b1;
      end else begin
        from_rb = 1'b1;
        if (volt_rb < cfg.volt_target) step_v = 1'b1;
        else if (curr_rb < cfg.curr_target) step_c = 1'b1;
      end
    end
    if (begin_c) begin
      nxt.needs_sample = 1'b0;
      if (zero_rb) begin
        ended = 1'b1;
      end else begin
        from_rb = 1'b1;
        if (curr_rb < cfg.curr_target) step_c = 1'b1;
      end
    end
    // a begin that does not step goes idle, whether it aborts or not
    if ((begin_v || begin_c) && !step_v && !step_c) begin
      nxt.phase        = ssr_pkg::PH_IDLE;
      nxt.delay_cnt    = '0;
      nxt.dwell_cnt    = '0;
      nxt.needs_sample = 1'b0;
    end
    if (from_rb) begin
      nxt.volt_level = volt_rb;
      nxt.curr_level = curr_rb;
    end

    v_base  = from_rb ? volt_rb : cur.volt_level;
    c_base  = from_rb ? curr_rb : cur.curr_level;
    v_sum   = {1'b0, v_base} + {1'b0, cfg.volt_incr};
    c_sum   = {1'b0, c_base} + {1'b0, cfg.curr_incr};
    v_clamp = (v_sum > {1'b0, cfg.volt_target}) ? cfg.volt_target
                                                : v_sum[ssr_pkg::VoltW-1:0];
    c_clamp = (c_sum > {1'b0, cfg.curr_target}) ? cfg.curr_target
                                                : c_sum[ssr_pkg::CurrW-1:0];

    if (step_v) begin
      wrote          = 1'b1;
      nxt.volt_level = v_clamp;
      if (v_clamp == cfg.volt_target) begin
        nxt.phase        = ssr_pkg::PH_CURR;
        nxt.needs_sample = 1'b1;
        nxt.dwell_cnt    = '0;
      end else begin
        nxt.phase     = ssr_pkg::PH_VOLT;
        nxt.dwell_cnt = cfg.volt_dwell;
      end
    end
    if (step_c) begin
      wrote          = 1'b1;
      nxt.curr_level = c_clamp;
      if (c_clamp == cfg.curr_target) begin
        nxt.phase        = ssr_pkg::PH_IDLE;
        nxt.delay_cnt    = '0;
        nxt.dwell_cnt    = '0;
        nxt.needs_sample = 1'b0;
      end else begin
        nxt.phase     = ssr_pkg::PH_CURR;
        nxt.dwell_cnt = cfg.curr_dwell;
      end
    end

    res.voltage_setpoint = wrote ? nxt.volt_level : '0;
    res.current_setpoint = wrote ? nxt.curr_level : '0;
    res.power_write      = wrote;
    res.delay_remaining  = nxt.delay_cnt;
    res.dwell_remaining  = nxt.dwell_cnt;
    res.ramp_phase       = nxt.phase;
    res.aborted          = ended;
  end

endmodule

/* sv/supply_soft_start_ramp_top.sv */
// supply_soft_start_ramp_top: soft-start ramp sequencer for a high-voltage supply.
// Depends on ssr_pkg, ssr_cfg_regs and ssr_step.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall  command, voltage and current readback
//  out_      output     out_valid/out_stall  setpoints, write flag, counts, phase, abort
//  cfg_      input      cfg_write_en         cfg_index, cfg_data (no read-back)
//
// Each item is captured in the input register and is then resolved into the
// result register; one item per cycle is sustained while the result is not
// stalled. The sequencer state is updated in the same edge that loads the
// result. A stalled result holds the input register, which then raises
// in_stall. Reset is synchronous, active low; it clears the sequencer to idle
// and loads the configuration defaults.
module supply_soft_start_ramp_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [ssr_pkg::VoltW-1:0]     in_voltage_readback,
  input  logic [ssr_pkg::CurrW-1:0]     in_current_readback,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssr_pkg::VoltW-1:0]     out_voltage_setpoint,
  output logic [ssr_pkg::CurrW-1:0]     out_current_setpoint,
  output logic                          out_power_write,
  output logic [ssr_pkg::SecW-1:0]      out_delay_remaining,
  output logic [ssr_pkg::SecW-1:0]      out_dwell_remaining,
  output logic [1:0]                    out_ramp_phase,
  output logic                          out_aborted,
  // configuration
  input  logic                          cfg_write_en,
  input  logic [ssr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ssr_pkg::CfgDataW-1:0]  cfg_data
);

  ssr_pkg::cfg_t       cfg;
  ssr_pkg::seq_state_t state_r, state_nxt;
  ssr_pkg::result_t    res_nxt, res_r;

  // input register
  logic                      in_vld_r;
  logic [1:0]                cmd_r;
  logic [ssr_pkg::VoltW-1:0] vrb_r;
  logic [ssr_pkg::CurrW-1:0] crb_r;
  logic                      out_vld_r;
  logic                      advance;

  ssr_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  ssr_step u_step (
    .cfg     (cfg),
    .cur     (state_r),
    .command (cmd_r),
    .volt_rb (vrb_r),
    .curr_rb (crb_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // result slot is free, or is being taken this cycle
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r <= in_command;
      vrb_r <= in_voltage_readback;
      crb_r <= in_current_readback;
    end
  end

  // sequencer state moves only when an item is resolved
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= ssr_pkg::PH_IDLE;
      state_r.volt_level   <= '0;
      state_r.curr_level   <= '0;
      state_r.delay_cnt    <= '0;
      state_r.dwell_cnt    <= '0;
      state_r.needs_sample <= 1'b0;
    end else if (advance && in_vld_r) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_voltage_setpoint = res_r.voltage_setpoint;
  assign out_current_setpoint = res_r.current_setpoint;
  assign out_power_write      = res_r.power_write;
  assign out_delay_remaining  = res_r.delay_remaining;
  assign out_dwell_remaining  = res_r.dwell_remaining;
  assign out_ramp_phase       = res_r.ramp_phase;
  assign out_aborted          = res_r.aborted;

endmodule
